// ----- design/fst_pkg.sv -----
// Package for the FIFO-to-stack transfer engine.
// Holds depths, payload structs, request and status codes, and the cell control struct.
// No dependencies.
package fst_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int STACK_DEPTH = 16;
    localparam int QCW         = $clog2(QUEUE_DEPTH + 1);
    localparam int SCW         = $clog2(STACK_DEPTH + 1);
    localparam int QIW         = $clog2(QUEUE_DEPTH);
    localparam int ID_W        = 16;

    typedef enum logic [1:0] {
        REQ_ENQ    = 2'd0,
        REQ_XFER   = 2'd1,
        REQ_DIRECT = 2'd2,
        REQ_EXIT   = 2'd3
    } t_req_kind;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_QEMPTY   = 3'd1,
        ST_SEMPTY   = 3'd2,
        ST_MISMATCH = 3'd3,
        ST_FULL     = 3'd4
    } t_status;

    typedef enum logic {
        S_IDLE  = 1'b0,
        S_PURGE = 1'b1
    } t_state;

    typedef struct packed {
        t_req_kind         req_type;
        logic [ID_W-1:0]   item_id;
    } t_req;

    typedef struct packed {
        t_status           status;
        logic [ID_W-1:0]   moved_id;
        logic [4:0]        queue_count;
        logic [4:0]        stack_count;
    } t_rsp;

    typedef struct packed {
        logic ld;
        logic shl;
        logic shr;
    } t_cell_ctrl;

    // low five bits of a fill count (fills fit in 9 bits)
    function automatic logic [4:0] f_cnt5(input logic [8:0] v);
        return v[4:0];
    endfunction

endpackage

// ----- design/fst_cell.sv -----
// One storage cell of the queue or stack chain.
// Loads a new id or takes its upper or lower neighbor's value; uses fst_pkg.
module fst_cell (
    input  logic                     i_clk,
    input  fst_pkg::t_cell_ctrl      i_ctrl,
    input  logic [fst_pkg::ID_W-1:0] i_load_data,
    input  logic [fst_pkg::ID_W-1:0] i_from_hi,
    input  logic [fst_pkg::ID_W-1:0] i_from_lo,
    output logic [fst_pkg::ID_W-1:0] o_data
);

    logic [fst_pkg::ID_W-1:0] r_data;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.ld) begin
            r_data <= i_load_data;
        end else if (i_ctrl.shl) begin
            r_data <= i_from_hi;
        end else if (i_ctrl.shr) begin
            r_data <= i_from_lo;
        end
    end

    assign o_data = r_data;

endmodule

// ----- design/fifo_to_stack_transfer_engine_top.sv -----
// FIFO-to-stack transfer engine: a queue chain and a stack chain of id cells plus control.
// Uses fst_pkg and fst_cell.
//
// Enqueue, transfer and exit are handled in S_IDLE; the response is registered and, with no
// earlier response waiting, shows in the cycle after the request transfer. Direct entry,
// unless the stack is full, pushes the id onto the stack at once, then scans the queue cells
// from the head, closing the gap at each matching cell by shifting the cells above it down.
// Requests are taken one at a time; a two-entry response buffer lets a new request in while an
// earlier response is still waiting. The queue head is cell 0; the stack top is cell 0.
module fifo_to_stack_transfer_engine_top (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_req_valid,
    output logic           o_req_ready,
    input  fst_pkg::t_req  i_req,
    output logic           o_rsp_valid,
    input  logic           i_rsp_ready,
    output fst_pkg::t_rsp  o_rsp
);

    localparam int QD  = fst_pkg::QUEUE_DEPTH;
    localparam int SD  = fst_pkg::STACK_DEPTH;
    localparam int QCW = fst_pkg::QCW;
    localparam int SCW = fst_pkg::SCW;
    localparam int QIW = fst_pkg::QIW;
    localparam int IW  = fst_pkg::ID_W;

    fst_pkg::t_state  r_state, n_state;
    logic [QCW-1:0]   r_qfill, n_qfill;
    logic [SCW-1:0]   r_sfill, n_sfill;
    logic [QCW-1:0]   r_ptr, n_ptr;
    logic [IW-1:0]    r_id, n_id;
    fst_pkg::t_rsp    r_obuf0, r_obuf1, n_obuf0, n_obuf1;
    logic [1:0]       r_ocnt, n_ocnt;

    logic [IW-1:0]       w_qdata [QD];
    logic [IW-1:0]       w_sdata [SD];
    fst_pkg::t_cell_ctrl w_qctrl [QD];
    fst_pkg::t_cell_ctrl w_sctrl [SD];

    logic           w_accept, w_pop, w_room, w_qfull, w_sfull, w_done, w_match;
    logic           w_q_ld, w_q_shl_all, w_q_shl_ptr, w_s_push, w_s_pop;
    logic [IW-1:0]  w_push_data;
    logic           w_rsp_push;
    fst_pkg::t_rsp  w_rsp_new;

    assign o_rsp_valid = (r_ocnt != 2'd0);
    assign o_rsp       = r_obuf0;
    assign o_req_ready = (r_state == fst_pkg::S_IDLE) && (r_ocnt != 2'd2);
    assign w_accept    = i_req_valid && o_req_ready;
    assign w_pop       = o_rsp_valid && i_rsp_ready;
    assign w_room      = (r_ocnt != 2'd2) || w_pop;
    assign w_qfull     = (r_qfill == QCW'(QD));
    assign w_sfull     = (r_sfill == SCW'(SD));
    assign w_done      = (r_ptr == r_qfill);
    assign w_match     = (w_qdata[r_ptr[QIW-1:0]] == r_id);

    // cell chains
    for (genvar j = 0; j < QD; j++) begin : g_q
        logic [IW-1:0] w_hi, w_lo;
        if (j + 1 < QD) begin : g_hi
            assign w_hi = w_qdata[j+1];
        end else begin : g_top
            assign w_hi = '0;
        end
        if (j > 0) begin : g_lo
            assign w_lo = w_qdata[j-1];
        end else begin : g_bot
            assign w_lo = '0;
        end
        fst_cell u_cell (
            .i_clk       (i_clk),
            .i_ctrl      (w_qctrl[j]),
            .i_load_data (i_req.item_id),
            .i_from_hi   (w_hi),
            .i_from_lo   (w_lo),
            .o_data      (w_qdata[j])
        );
    end

    for (genvar j = 0; j < SD; j++) begin : g_s
        logic [IW-1:0] w_hi, w_lo;
        if (j + 1 < SD) begin : g_hi
            assign w_hi = w_sdata[j+1];
        end else begin : g_top
            assign w_hi = '0;
        end
        if (j > 0) begin : g_lo
            assign w_lo = w_sdata[j-1];
        end else begin : g_bot
            assign w_lo = '0;
        end
        fst_cell u_cell (
            .i_clk       (i_clk),
            .i_ctrl      (w_sctrl[j]),
            .i_load_data (w_push_data),
            .i_from_hi   (w_hi),
            .i_from_lo   (w_lo),
            .o_data      (w_sdata[j])
        );
    end

    always_comb begin
        for (int j = 0; j < QD; j++) begin
            w_qctrl[j].ld  = w_q_ld && (QCW'(j) == r_qfill);
            w_qctrl[j].shl = w_q_shl_all || (w_q_shl_ptr && (QCW'(j) >= r_ptr));
            w_qctrl[j].shr = 1'b0;
        end
        for (int j = 0; j < SD; j++) begin
            w_sctrl[j].ld  = w_s_push && (j == 0);
            w_sctrl[j].shl = w_s_pop;
            w_sctrl[j].shr = w_s_push;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            fst_pkg::S_IDLE: begin
                if (w_accept && i_req.req_type == fst_pkg::REQ_DIRECT && !w_sfull) begin
                    n_state = fst_pkg::S_PURGE;
                end
            end
            fst_pkg::S_PURGE: begin
                if (w_done && w_room) begin
                    n_state = fst_pkg::S_IDLE;
                end
            end
            default: n_state = fst_pkg::S_IDLE;
        endcase
    end

    // datapath control and response
    always_comb begin
        n_qfill     = r_qfill;
        n_sfill     = r_sfill;
        n_ptr       = r_ptr;
        n_id        = r_id;
        w_q_ld      = 1'b0;
        w_q_shl_all = 1'b0;
        w_q_shl_ptr = 1'b0;
        w_s_push    = 1'b0;
        w_s_pop     = 1'b0;
        w_push_data = i_req.item_id;
        w_rsp_push  = 1'b0;
        w_rsp_new   = '0;
        w_rsp_new.status   = fst_pkg::ST_OK;
        w_rsp_new.moved_id = '0;
        unique case (r_state)
            fst_pkg::S_IDLE: begin
                if (w_accept) begin
                    w_rsp_push = 1'b1;
                    unique case (i_req.req_type)
                        fst_pkg::REQ_ENQ: begin
                            if (w_qfull) begin
                                w_rsp_new.status = fst_pkg::ST_FULL;
                            end else begin
                                w_q_ld             = 1'b1;
                                n_qfill            = r_qfill + 1'b1;
                                w_rsp_new.moved_id = i_req.item_id;
                            end
                        end
                        fst_pkg::REQ_XFER: begin
                            if (r_qfill == '0) begin
                                w_rsp_new.status = fst_pkg::ST_QEMPTY;
                            end else if (w_sfull) begin
                                w_rsp_new.status = fst_pkg::ST_FULL;
                            end else begin
                                w_q_shl_all        = 1'b1;
                                w_s_push           = 1'b1;
                                w_push_data        = w_qdata[0];
                                n_qfill            = r_qfill - 1'b1;
                                n_sfill            = r_sfill + 1'b1;
                                w_rsp_new.moved_id = w_qdata[0];
                            end
                        end
                        fst_pkg::REQ_DIRECT: begin
                            if (w_sfull) begin
                                w_rsp_new.status = fst_pkg::ST_FULL;
                            end else begin
                                w_rsp_push = 1'b0;
                                w_s_push   = 1'b1;
                                n_sfill    = r_sfill + 1'b1;
                                n_ptr      = '0;
                                n_id       = i_req.item_id;
                            end
                        end
                        fst_pkg::REQ_EXIT: begin
                            if (r_sfill == '0) begin
                                w_rsp_new.status = fst_pkg::ST_SEMPTY;
                            end else if (w_sdata[0] != i_req.item_id) begin
                                w_rsp_new.status = fst_pkg::ST_MISMATCH;
                            end else begin
                                w_s_pop            = 1'b1;
                                n_sfill            = r_sfill - 1'b1;
                                w_rsp_new.moved_id = i_req.item_id;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            fst_pkg::S_PURGE: begin
                if (w_done) begin
                    w_rsp_push         = w_room;
                    w_rsp_new.moved_id = r_id;
                end else if (w_match) begin
                    w_q_shl_ptr = 1'b1;
                    n_qfill     = r_qfill - 1'b1;
                end else begin
                    n_ptr = r_ptr + 1'b1;
                end
            end
            default: ;
        endcase
        w_rsp_new.queue_count = fst_pkg::f_cnt5(9'(n_qfill));
        w_rsp_new.stack_count = fst_pkg::f_cnt5(9'(n_sfill));
    end

    // two-entry response buffer
    always_comb begin
        n_obuf0 = r_obuf0;
        n_obuf1 = r_obuf1;
        n_ocnt  = r_ocnt;
        if (w_pop && w_rsp_push) begin
            if (r_ocnt == 2'd1) begin
                n_obuf0 = w_rsp_new;
            end else begin
                n_obuf0 = r_obuf1;
                n_obuf1 = w_rsp_new;
            end
        end else if (w_pop) begin
            n_obuf0 = r_obuf1;
            n_ocnt  = r_ocnt - 2'd1;
        end else if (w_rsp_push) begin
            if (r_ocnt == 2'd0) begin
                n_obuf0 = w_rsp_new;
            end else begin
                n_obuf1 = w_rsp_new;
            end
            n_ocnt = r_ocnt + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fst_pkg::S_IDLE;
            r_qfill <= '0;
            r_sfill <= '0;
            r_ptr   <= '0;
            r_ocnt  <= '0;
        end else begin
            r_state <= n_state;
            r_qfill <= n_qfill;
            r_sfill <= n_sfill;
            r_ptr   <= n_ptr;
            r_ocnt  <= n_ocnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_id    <= n_id;
        r_obuf0 <= n_obuf0;
        r_obuf1 <= n_obuf1;
    end

endmodule

// ----- design/fst_checker.sv -----
// Port-level checker for the FIFO-to-stack transfer engine, bound to the top level.
// Uses fst_pkg.
module fst_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_req_valid,
    input logic           o_req_ready,
    input fst_pkg::t_req  i_req,
    input logic           o_rsp_valid,
    input logic           i_rsp_ready,
    input fst_pkg::t_rsp  o_rsp
);

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && !i_rsp_ready |=> o_rsp_valid && $stable(o_rsp))
        else $error("response dropped or changed while stalled");

    a_reset_clean: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_rsp_valid && o_req_ready)
        else $error("not idle after reset");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && o_rsp.status != fst_pkg::ST_OK |-> o_rsp.moved_id == '0)
        else $error("failed request reports a moved id");

    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && (o_rsp.status == fst_pkg::ST_QEMPTY
                        || o_rsp.status == fst_pkg::ST_SEMPTY)
        |-> (o_rsp.status != fst_pkg::ST_QEMPTY || o_rsp.queue_count == 5'd0)
            && (o_rsp.status != fst_pkg::ST_SEMPTY || o_rsp.stack_count == 5'd0))
        else $error("empty status with nonzero count");

endmodule

bind fifo_to_stack_transfer_engine_top fst_checker u_fst_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req_valid),
    .o_req_ready (o_req_ready),
    .i_req       (i_req),
    .o_rsp_valid (o_rsp_valid),
    .i_rsp_ready (i_rsp_ready),
    .o_rsp       (o_rsp)
);

// ----- bench/fifo_to_stack_transfer_engine_top_tb.sv -----
// Testbench for fifo_to_stack_transfer_engine_top: directed and random request streams with
// random idling on both channels, checked against a queue/stack predictor in a scoreboard.
// Depends on fst_pkg and the engine RTL.
`timescale 1ns / 100ps

module fifo_to_stack_transfer_engine_top_tb;
    import fst_pkg::*;

    localparam int STALL_LIMIT  = 1000;
    localparam int LONG_HOLD    = 200;
    localparam int TAIL_CYCLES  = 2 * (QUEUE_DEPTH + 2);
    localparam int SEGMENTS     = 19;
    localparam int SEG_ITEMS    = 50;

    typedef enum int {
        MIX_BALANCED    = 0,
        MIX_FILL_QUEUE  = 1,
        MIX_FILL_STACK  = 2,
        MIX_DRAIN       = 3
    } t_mix;

    class fst_scoreboard;
        logic [ID_W-1:0] queue_ids[$];
        logic [ID_W-1:0] stack_ids[$];   // back is the top
        t_rsp            expected_rsp[$];
        int              errors = 0;

        function void note_request(t_req req);
            t_rsp            rsp;
            logic [ID_W-1:0] kept[$];
            rsp.status   = ST_OK;
            rsp.moved_id = '0;
            case (req.req_type)
                REQ_ENQ: begin
                    if (queue_ids.size() >= QUEUE_DEPTH) begin
                        rsp.status = ST_FULL;
                    end else begin
                        queue_ids.insert(queue_ids.size(), req.item_id);
                        rsp.moved_id = req.item_id;
                    end
                end
                REQ_XFER: begin
                    if (queue_ids.size() == 0) begin
                        rsp.status = ST_QEMPTY;
                    end else if (stack_ids.size() >= STACK_DEPTH) begin
                        rsp.status = ST_FULL;
                    end else begin
                        rsp.moved_id = queue_ids[0];
                        queue_ids.delete(0);
                        stack_ids.insert(stack_ids.size(), rsp.moved_id);
                    end
                end
                REQ_DIRECT: begin
                    if (stack_ids.size() >= STACK_DEPTH) begin
                        rsp.status = ST_FULL;
                    end else begin
                        foreach (queue_ids[i]) begin
                            if (queue_ids[i] != req.item_id)
                                kept.insert(kept.size(), queue_ids[i]);
                        end
                        queue_ids = kept;
                        stack_ids.insert(stack_ids.size(), req.item_id);
                        rsp.moved_id = req.item_id;
                    end
                end
                default: begin
                    if (stack_ids.size() == 0) begin
                        rsp.status = ST_SEMPTY;
                    end else if (stack_ids[$] != req.item_id) begin
                        rsp.status = ST_MISMATCH;
                    end else begin
                        stack_ids.delete(stack_ids.size() - 1);
                        rsp.moved_id = req.item_id;
                    end
                end
            endcase
            rsp.queue_count = 5'(queue_ids.size());
            rsp.stack_count = 5'(stack_ids.size());
            expected_rsp.insert(expected_rsp.size(), rsp);
        endfunction

        function void check_response(t_rsp got);
            t_rsp want;
            if (expected_rsp.size() == 0) begin
                $error("unexpected response: status %0d moved_id %h", got.status, got.moved_id);
                errors++;
                return;
            end
            want = expected_rsp[0];
            expected_rsp.delete(0);
            if (got.status !== want.status) begin
                $error("status: expected %0d, actual %0d", want.status, got.status);
                errors++;
            end
            if (got.moved_id !== want.moved_id) begin
                $error("moved_id: expected %h, actual %h", want.moved_id, got.moved_id);
                errors++;
            end
            if (got.queue_count !== want.queue_count) begin
                $error("queue_count: expected %0d, actual %0d", want.queue_count,
                       got.queue_count);
                errors++;
            end
            if (got.stack_count !== want.stack_count) begin
                $error("stack_count: expected %0d, actual %0d", want.stack_count,
                       got.stack_count);
                errors++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n     = 1'b0;
    logic i_req_valid = 1'b0;
    logic o_req_ready;
    t_req i_req       = '0;
    logic o_rsp_valid;
    logic i_rsp_ready = 1'b0;
    t_rsp o_rsp;

    fst_scoreboard   sb = new;
    logic [ID_W-1:0] id_pool [4];
    bit              req_idling    = 1'b1;
    bit              rsp_idling    = 1'b1;
    bit              long_hold_req = 1'b0;
    int              quiet_cycles  = 0;
    int              stall_left    = 0;

    fifo_to_stack_transfer_engine_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_ready (o_req_ready),
        .i_req       (i_req),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_ready (i_rsp_ready),
        .o_rsp       (o_rsp)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    task automatic send_request(input t_req req);
        i_req_valid <= 1'b1;
        i_req       <= req;
        do @(posedge i_clk); while (!o_req_ready);
        sb.note_request(req);
        if (req_idling && $urandom_range(0, 5) == 0) begin
            i_req_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
        end
    endtask

    task automatic wait_all_responses();
        i_req_valid <= 1'b0;
        while (sb.expected_rsp.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [ID_W-1:0] pick_id();
        if ($urandom_range(0, 9) < 7) return id_pool[$urandom_range(0, 3)];
        return ID_W'($urandom);
    endfunction

    function automatic t_req pick_request(t_mix mix);
        t_req req;
        int   r;
        int   enq_lim;
        int   xfer_lim;
        int   dir_lim;
        r = $urandom_range(0, 99);
        case (mix)
            MIX_FILL_QUEUE: begin enq_lim = 75; xfer_lim = 85; dir_lim = 92; end
            MIX_FILL_STACK: begin enq_lim = 40; xfer_lim = 75; dir_lim = 95; end
            MIX_DRAIN:      begin enq_lim = 10; xfer_lim = 25; dir_lim = 35; end
            default:        begin enq_lim = 35; xfer_lim = 55; dir_lim = 75; end
        endcase
        req.item_id = pick_id();
        if (r < enq_lim) begin
            req.req_type = REQ_ENQ;
        end else if (r < xfer_lim) begin
            req.req_type = REQ_XFER;
        end else if (r < dir_lim) begin
            req.req_type = REQ_DIRECT;
            if (sb.queue_ids.size() != 0 && $urandom_range(0, 9) < 4)
                req.item_id = sb.queue_ids[$urandom_range(0, sb.queue_ids.size() - 1)];
        end else begin
            req.req_type = REQ_EXIT;
            if (sb.stack_ids.size() != 0 && $urandom_range(0, 99) < 80)
                req.item_id = sb.stack_ids[$];
        end
        return req;
    endfunction

    // response side: checks and random backpressure
    initial begin
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_rsp_valid && i_rsp_ready) sb.check_response(o_rsp);
            if (long_hold_req) begin
                stall_left    = LONG_HOLD;
                long_hold_req = 1'b0;
            end else if (stall_left == 0 && rsp_idling && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(1, 17);
            end
            if (stall_left > 0) begin
                i_rsp_ready <= 1'b0;
                stall_left--;
            end else begin
                i_rsp_ready <= 1'b1;
            end
        end
    end

    initial begin
        forever begin
            @(posedge i_clk);
            if ((i_req_valid && o_req_ready) || (o_rsp_valid && i_rsp_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    initial begin
        t_req directed[$];
        t_mix mix;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        directed.insert(directed.size(), t_req'{REQ_XFER,   16'hFFFF});   // queue empty
        directed.insert(directed.size(), t_req'{REQ_EXIT,   16'h0000});   // stack empty
        directed.insert(directed.size(), t_req'{REQ_ENQ,    16'h0000});
        directed.insert(directed.size(), t_req'{REQ_ENQ,    16'hFFFF});
        directed.insert(directed.size(), t_req'{REQ_ENQ,    16'h5A5A});
        directed.insert(directed.size(), t_req'{REQ_ENQ,    16'hFFFF});
        directed.insert(directed.size(), t_req'{REQ_DIRECT, 16'hFFFF});   // purges both copies
        directed.insert(directed.size(), t_req'{REQ_DIRECT, 16'hA5A5});   // id not queued
        directed.insert(directed.size(), t_req'{REQ_EXIT,   16'h0000});   // top mismatch
        directed.insert(directed.size(), t_req'{REQ_EXIT,   16'hA5A5});
        directed.insert(directed.size(), t_req'{REQ_XFER,   16'h0000});
        directed.insert(directed.size(), t_req'{REQ_EXIT,   16'h0000});
        directed.insert(directed.size(), t_req'{REQ_EXIT,   16'hFFFF});
        directed.insert(directed.size(), t_req'{REQ_DIRECT, 16'h5A5A});   // empties the queue
        directed.insert(directed.size(), t_req'{REQ_EXIT,   16'h5A5A});
        foreach (directed[i]) send_request(directed[i]);

        for (int seg = 0; seg < SEGMENTS; seg++) begin
            foreach (id_pool[i]) id_pool[i] = ID_W'($urandom);
            mix = (seg < 8) ? t_mix'(seg % 4) : t_mix'($urandom_range(0, 3));
            if (seg >= SEGMENTS - 3) begin
                req_idling = 1'b0;
                rsp_idling = 1'b0;
            end else begin
                req_idling = ($urandom_range(0, 3) != 0);
                rsp_idling = ($urandom_range(0, 3) != 0);
            end
            if (seg == 4) long_hold_req = 1'b1;
            if (seg == 9) wait_all_responses();
            repeat (SEG_ITEMS) send_request(pick_request(mix));
        end

        wait_all_responses();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (sb.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule

// ----- fifo_to_stack_transfer_engine_top.f -----
design/fst_pkg.sv
design/fst_cell.sv
design/fifo_to_stack_transfer_engine_top.sv
design/fst_checker.sv
bench/fifo_to_stack_transfer_engine_top_tb.sv
